### sv/scst_pkg.sv
`default_nettype none

package scst_pkg;

  localparam int NUM_SEMS  = 16;
  localparam int NUM_PROCS = 16;

  localparam int REQ_W  = 2;
  localparam int PROC_W = 8;
  localparam int SEM_IW = 4;
  localparam int INIT_W = 15;
  localparam int CNT_W  = 16;

  localparam int SEM_AW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int SLOT_IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int ROW_W   = NUM_PROCS * PROC_W;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_WAIT   = 2'd1,
    REQ_SIGNAL = 2'd2
  } req_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } scst_cmd_t;

  function automatic logic [SEM_AW-1:0] first_sem(input logic [NUM_SEMS-1:0] vec);
    logic [SEM_AW-1:0] idx;
    idx = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (vec[i]) idx = SEM_AW'(i);
    end
    return idx;
  endfunction

  function automatic logic [SLOT_IW-1:0] first_slot(input logic [NUM_PROCS-1:0] vec);
    logic [SLOT_IW-1:0] idx;
    idx = '0;
    for (int i = NUM_PROCS - 1; i >= 0; i--) begin
      if (vec[i]) idx = SLOT_IW'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### sv/scst_ram.sv
`default_nettype none

module scst_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_W-1:0]    waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_W-1:0]    raddr,
  output logic      [WIDTH-1:0]     rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### sv/scst_ctrl.sv
`default_nettype none

module scst_ctrl
  import scst_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output scst_cmd_t cmd,
  output logic      out_valid_r
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EXEC);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    busy        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### sv/scst_dpath.sv
`default_nettype none

module scst_dpath
  import scst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scst_cmd_t         cmd,
  input  wire logic [REQ_W-1:0]  in_req_type,
  input  wire logic [PROC_W-1:0] in_proc_id,
  input  wire logic [SEM_IW-1:0] in_sem_id,
  input  wire logic [INIT_W-1:0] in_init_value,
  output logic                   out_status_r,
  output logic [SEM_IW-1:0]      out_alloc_sem_r,
  output logic                   out_block_caller_r,
  output logic                   out_wake_valid_r,
  output logic [PROC_W-1:0]      out_wake_proc_r
);

  // latched request
  logic [REQ_W-1:0]  req_r;
  logic [PROC_W-1:0] proc_r;
  logic [SEM_IW-1:0] sem_r;
  logic [INIT_W-1:0] init_r;

  // table state
  logic [NUM_SEMS-1:0]           in_use_r;
  logic signed [CNT_W-1:0]       cnt_r      [NUM_SEMS];
  logic [NUM_PROCS-1:0]          slot_full_r[NUM_SEMS];
  logic [NUM_SEMS-1:0]           woken_v_r;
  logic [SLOT_IW-1:0]            woken_idx_r[NUM_SEMS];

  logic [ROW_W-1:0]              row_rdata;
  logic [ROW_W-1:0]              row_wdata;
  logic                          row_we;

  logic [SEM_AW-1:0]             sem_a;
  logic                          sem_ok;
  logic [NUM_PROCS-1:0]          row_full;
  logic signed [CNT_W-1:0]       cnt;
  logic signed [CNT_W-1:0]       cnt_dec;
  logic signed [CNT_W-1:0]       cnt_inc;
  logic                          free_any;
  logic [SEM_AW-1:0]             free_idx;
  logic                          empty_any;
  logic [SLOT_IW-1:0]            empty_idx;
  logic [SLOT_IW:0]              scan_start;
  logic [SLOT_IW:0]              woken_nxt;
  logic [NUM_PROCS-1:0]          hi_mask;
  logic [NUM_PROCS-1:0]          hi_hits;
  logic                          hit_any;
  logic [SLOT_IW-1:0]            hit_idx;

  logic                          do_alloc;
  logic                          do_wait;
  logic                          do_signal;
  logic                          wait_store;
  logic                          res_status;
  logic [SEM_IW-1:0]             res_alloc_sem;
  logic                          res_block;
  logic                          res_wake_valid;
  logic [PROC_W-1:0]             res_wake_proc;

  scst_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SEMS)
  ) u_slot_ram (
    .clk     (clk),
    .we      (row_we),
    .waddr   (sem_a),
    .wdata   (row_wdata),
    .re      (cmd.capture),
    .raddr   (SEM_AW'(in_sem_id)),
    .rdata_r (row_rdata)
  );

  always_comb begin
    sem_a     = SEM_AW'(sem_r);
    sem_ok    = (32'(sem_r) < NUM_SEMS);
    row_full  = slot_full_r[sem_a];
    cnt       = cnt_r[sem_a];
    cnt_dec   = (cnt == CNT_MIN) ? cnt : cnt - 16'sd1;
    cnt_inc   = (cnt == CNT_MAX) ? cnt : cnt + 16'sd1;

    free_any  = |(~in_use_r);
    free_idx  = first_sem(~in_use_r);
    empty_any = |(~row_full);
    empty_idx = first_slot(~row_full);

    // circular scan: slots at or above the start first, then wrap to zero
    woken_nxt  = {1'b0, woken_idx_r[sem_a]} + 1'b1;
    scan_start = (woken_v_r[sem_a] && (32'(woken_nxt) < NUM_PROCS)) ? woken_nxt : '0;
    for (int i = 0; i < NUM_PROCS; i++) begin
      hi_mask[i] = ((SLOT_IW + 1)'(i) >= scan_start);
    end
    hi_hits = row_full & hi_mask;
    hit_any = |row_full;
    hit_idx = (|hi_hits) ? first_slot(hi_hits) : first_slot(row_full);

    do_alloc  = 1'b0;
    do_wait   = 1'b0;
    do_signal = 1'b0;
    unique case (req_r)
      REQ_ALLOC:  do_alloc  = 1'b1;
      REQ_WAIT:   do_wait   = sem_ok;
      REQ_SIGNAL: do_signal = sem_ok;
      default: ;
    endcase

    wait_store = do_wait && cnt_dec[CNT_W-1] && empty_any;

    row_wdata = row_rdata;
    row_wdata[empty_idx*PROC_W +: PROC_W] = proc_r;
    row_we    = cmd.execute && wait_store;

    res_status     = do_alloc && !free_any;
    res_alloc_sem  = (do_alloc && free_any) ? SEM_IW'(free_idx) : '0;
    res_block      = do_wait && cnt_dec[CNT_W-1];
    res_wake_valid = do_signal && hit_any;
    res_wake_proc  = res_wake_valid ? row_rdata[hit_idx*PROC_W +: PROC_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req_type;
      proc_r <= in_proc_id;
      sem_r  <= in_sem_id;
      init_r <= in_init_value;
    end
    if (cmd.execute) begin
      out_status_r       <= res_status;
      out_alloc_sem_r    <= res_alloc_sem;
      out_block_caller_r <= res_block;
      out_wake_valid_r   <= res_wake_valid;
      out_wake_proc_r    <= res_wake_proc;
      if (do_alloc && free_any) cnt_r[free_idx] <= signed'({1'b0, init_r});
      if (do_wait)              cnt_r[sem_a]    <= cnt_dec;
      if (do_signal)            cnt_r[sem_a]    <= cnt_inc;
      if (res_wake_valid)       woken_idx_r[sem_a] <= hit_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r  <= '0;
      woken_v_r <= '0;
      for (int s = 0; s < NUM_SEMS; s++) begin
        slot_full_r[s] <= '0;
      end
    end else if (cmd.execute) begin
      if (do_alloc && free_any) in_use_r[free_idx] <= 1'b1;
      if (wait_store)           slot_full_r[sem_a][empty_idx] <= 1'b1;
      if (res_wake_valid) begin
        slot_full_r[sem_a][hit_idx] <= 1'b0;
        woken_v_r[sem_a]            <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/counting_semaphore_table_top.sv
`default_nettype none

// Counting semaphore table with per-semaphore wait slots.
// Input channel: drive in_req_type, in_proc_id, in_sem_id and in_init_value
// with start high; the beat is taken at a rising edge where busy is low.
// Request codes: allocate, wait, signal; the unused code returns all zeros.
// Result channel: out_valid strobes high for exactly one cycle carrying
// out_status, out_alloc_sem, out_block_caller, out_wake_valid, out_wake_proc.
// The receiver cannot stall; each result must be taken in its strobe cycle.
// The result registers and the out_valid strobe are loaded at the end of the
// execute state, and the result is taken at the end of its strobe cycle.
// A request is captured in the idle state, which reads the semaphore's
// wait-slot row from the slot RAM; the execute state updates count, slot
// bits and the row, and registers the result. busy is high in the execute
// state only, so a new request is taken while the result is shown.
// Reset (rst_n low, synchronous): no semaphore allocated, all wait slots
// empty, wake scans start at slot zero; no clearing pass is needed.
// Counts of never-allocated semaphores are undefined until allocated.
module counting_semaphore_table_top
  import scst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [REQ_W-1:0]  in_req_type,
  input  wire logic [PROC_W-1:0] in_proc_id,
  input  wire logic [SEM_IW-1:0] in_sem_id,
  input  wire logic [INIT_W-1:0] in_init_value,
  output logic                   out_valid,
  output logic                   out_status,
  output logic [SEM_IW-1:0]      out_alloc_sem,
  output logic                   out_block_caller,
  output logic                   out_wake_valid,
  output logic [PROC_W-1:0]      out_wake_proc
);

  scst_cmd_t cmd;

  scst_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .out_valid_r (out_valid)
  );

  scst_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_req_type        (in_req_type),
    .in_proc_id         (in_proc_id),
    .in_sem_id          (in_sem_id),
    .in_init_value      (in_init_value),
    .out_status_r       (out_status),
    .out_alloc_sem_r    (out_alloc_sem),
    .out_block_caller_r (out_block_caller),
    .out_wake_valid_r   (out_wake_valid),
    .out_wake_proc_r    (out_wake_proc)
  );

`ifndef ASSERT_OFF
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not enter execute");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && out_valid))
    else $error("execute did not end with a result strobe");

  a_strobe_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an executed request");

  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (!out_block_caller && !out_wake_valid))
    else $error("allocate failure combined with wait or signal result");
`endif

endmodule

`default_nettype wire

### verif/counting_semaphore_table_monitor.sv
`timescale 1ns / 1ps

module counting_semaphore_table_monitor
  import scst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [REQ_W-1:0]  in_req_type,
  input  wire logic [PROC_W-1:0] in_proc_id,
  input  wire logic [SEM_IW-1:0] in_sem_id,
  input  wire logic [INIT_W-1:0] in_init_value,
  input  wire logic              out_valid,
  input  wire logic              out_status,
  input  wire logic [SEM_IW-1:0] out_alloc_sem,
  input  wire logic              out_block_caller,
  input  wire logic              out_wake_valid,
  input  wire logic [PROC_W-1:0] out_wake_proc,
  output int                     mismatch_cnt,
  output int                     pending
);

  typedef struct packed {
    logic              status;
    logic [SEM_IW-1:0] alloc_sem;
    logic              block_caller;
    logic              wake_valid;
    logic [PROC_W-1:0] wake_proc;
  } reply_t;

  reply_t expected_replies[$];

  logic                    sem_taken  [NUM_SEMS];
  logic signed [CNT_W-1:0] sem_cnt    [NUM_SEMS];
  logic                    slot_full  [NUM_SEMS][NUM_PROCS];
  logic [PROC_W-1:0]       slot_proc  [NUM_SEMS][NUM_PROCS];
  logic                    woken_vld  [NUM_SEMS];
  logic [SLOT_IW-1:0]      woken_ix   [NUM_SEMS];

  function automatic reply_t apply_request(input logic [REQ_W-1:0] req,
                                           input logic [PROC_W-1:0] proc,
                                           input logic [SEM_IW-1:0] sem,
                                           input logic [INIT_W-1:0] init);
    reply_t r;
    logic   done;
    int     first;
    int     s;
    r = '0;
    done = 1'b0;
    case (req)
      REQ_ALLOC: begin
        for (int i = 0; i < NUM_SEMS; i++) begin
          if (!done && !sem_taken[i]) begin
            done = 1'b1;
            sem_taken[i] = 1'b1;
            sem_cnt[i] = {1'b0, init};
            r.alloc_sem = SEM_IW'(i);
          end
        end
        if (!done) r.status = 1'b1;
      end
      REQ_WAIT: begin
        if (int'(sem) < NUM_SEMS) begin
          if (sem_cnt[sem] != CNT_MIN) sem_cnt[sem] = sem_cnt[sem] - 16'sd1;
          if (sem_cnt[sem][CNT_W-1]) begin
            r.block_caller = 1'b1;
            for (int i = 0; i < NUM_PROCS; i++) begin
              if (!done && !slot_full[sem][i]) begin
                done = 1'b1;
                slot_full[sem][i] = 1'b1;
                slot_proc[sem][i] = proc;
              end
            end
          end
        end
      end
      REQ_SIGNAL: begin
        if (int'(sem) < NUM_SEMS) begin
          if (sem_cnt[sem] != CNT_MAX) sem_cnt[sem] = sem_cnt[sem] + 16'sd1;
          first = woken_vld[sem] ? (int'(woken_ix[sem]) + 1) % NUM_PROCS : 0;
          for (int k = 0; k < NUM_PROCS; k++) begin
            s = (first + k) % NUM_PROCS;
            if (!done && slot_full[sem][s]) begin
              done = 1'b1;
              slot_full[sem][s] = 1'b0;
              r.wake_valid = 1'b1;
              r.wake_proc = slot_proc[sem][s];
              woken_vld[sem] = 1'b1;
              woken_ix[sem] = SLOT_IW'(s);
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t seen;
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        sem_taken[i] = 1'b0;
        sem_cnt[i] = '0;
        woken_vld[i] = 1'b0;
        woken_ix[i] = '0;
        for (int j = 0; j < NUM_PROCS; j++) begin
          slot_full[i][j] = 1'b0;
          slot_proc[i][j] = '0;
        end
      end
      expected_replies.delete();
      mismatch_cnt = 0;
      pending = 0;
    end else begin
      if (out_valid) begin
        seen = '{out_status, out_alloc_sem, out_block_caller, out_wake_valid, out_wake_proc};
        if (expected_replies.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: unexpected result status=%0d alloc_sem=%0d block=%0d wake=%0d/%0h",
                     $realtime, seen.status, seen.alloc_sem, seen.block_caller,
                     seen.wake_valid, seen.wake_proc);
          mismatch_cnt = mismatch_cnt + 1;
        end else begin
          want = expected_replies.pop_front();
          if (seen !== want) begin
            if (mismatch_cnt < 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected status=%0d alloc_sem=%0d block=%0d wake=%0d/%0h",
                       want.status, want.alloc_sem, want.block_caller,
                       want.wake_valid, want.wake_proc);
              $display("  actual   status=%0d alloc_sem=%0d block=%0d wake=%0d/%0h",
                       seen.status, seen.alloc_sem, seen.block_caller,
                       seen.wake_valid, seen.wake_proc);
            end
            mismatch_cnt = mismatch_cnt + 1;
          end
        end
      end
      if (start && !busy)
        expected_replies.push_back(apply_request(in_req_type, in_proc_id, in_sem_id,
                                                 in_init_value));
      pending = expected_replies.size();
    end
  end

endmodule

### verif/tb_counting_semaphore_table_top.sv
`timescale 1ns / 1ps

module tb_counting_semaphore_table_top;
  import scst_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SAT_WAITS    = 40;
  localparam int RANDOM_ITEMS = 1080;
  localparam int SAT_SEM      = NUM_SEMS - 1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [REQ_W-1:0]  in_req_type = '0;
  logic [PROC_W-1:0] in_proc_id = '0;
  logic [SEM_IW-1:0] in_sem_id = '0;
  logic [INIT_W-1:0] in_init_value = '0;
  logic              out_valid;
  logic              out_status;
  logic [SEM_IW-1:0] out_alloc_sem;
  logic              out_block_caller;
  logic              out_wake_valid;
  logic [PROC_W-1:0] out_wake_proc;

  int errors;
  int pending;
  int cycles = 0;
  int gap_mode = 1;

  always #5 clk = ~clk;

  counting_semaphore_table_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_proc_id       (in_proc_id),
    .in_sem_id        (in_sem_id),
    .in_init_value    (in_init_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_alloc_sem    (out_alloc_sem),
    .out_block_caller (out_block_caller),
    .out_wake_valid   (out_wake_valid),
    .out_wake_proc    (out_wake_proc)
  );

  counting_semaphore_table_monitor u_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_proc_id       (in_proc_id),
    .in_sem_id        (in_sem_id),
    .in_init_value    (in_init_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_alloc_sem    (out_alloc_sem),
    .out_block_caller (out_block_caller),
    .out_wake_valid   (out_wake_valid),
    .out_wake_proc    (out_wake_proc),
    .mismatch_cnt     (errors),
    .pending          (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_mode == 0 || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue(input logic [REQ_W-1:0] req, input logic [PROC_W-1:0] proc,
                       input logic [SEM_IW-1:0] sem, input logic [INIT_W-1:0] init);
    in_req_type <= req;
    in_proc_id <= proc;
    in_sem_id <= sem;
    in_init_value <= init;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  initial begin
    int                pick;
    logic [REQ_W-1:0]  req;
    logic [SEM_IW-1:0] sem;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(REQ_ALLOC, 8'h00, 4'h0, 15'd0);
    pause_sender();
    issue(REQ_ALLOC, 8'hff, 4'hf, 15'h7fff);
    pause_sender();
    // signal at the top of the range, nobody waiting
    issue(REQ_SIGNAL, 8'h00, 4'h1, 15'h0000);
    issue(REQ_WAIT, 8'h11, 4'h1, 15'h0000);
    issue(REQ_UNUSED, 8'hff, 4'hf, 15'h7fff);
    issue(REQ_WAIT, 8'hff, 4'h0, 15'h7fff);
    issue(REQ_WAIT, 8'h00, 4'h0, 15'h0000);
    issue(REQ_WAIT, 8'ha5, 4'h0, 15'h2aaa);
    issue(REQ_SIGNAL, 8'h00, 4'h0, 15'h5555);
    issue(REQ_WAIT, 8'h5a, 4'h0, 15'h0000);
    // wake order follows the slot after the last one woken, then wraps
    repeat (4) issue(REQ_SIGNAL, 8'h00, 4'h0, 15'h0000);
    pause_sender();
    for (int i = 2; i < NUM_SEMS; i++) begin
      issue(REQ_ALLOC, PROC_W'($urandom), SEM_IW'($urandom),
            (i == SAT_SEM) ? 15'd0 : INIT_W'($urandom_range(0, 3)));
      pause_sender();
    end
    // table full
    issue(REQ_ALLOC, 8'h00, 4'h0, 15'd1);
    drain();

    // overflow the wait slots of one semaphore
    for (int n = 0; n < SAT_WAITS; n++)
      issue(REQ_WAIT, PROC_W'($urandom), SEM_IW'(SAT_SEM), INIT_W'($urandom));
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) gap_mode = $urandom_range(0, 3);
      if (n % 300 == 299) drain();
      pick = $urandom_range(0, 99);
      if (pick < 4) req = REQ_ALLOC;
      else if (pick < 8) req = REQ_UNUSED;
      else if (pick < 54) req = REQ_WAIT;
      else req = REQ_SIGNAL;
      if ($urandom_range(0, 3) != 0) sem = SEM_IW'($urandom_range(0, 3));
      else sem = SEM_IW'($urandom);
      issue(req, PROC_W'($urandom), sem, INIT_W'($urandom));
      pause_sender();
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
